/* rtl/core/odq_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// odq_pkg: shared types and constants of the ordered keyed deque
// Entry layout, chain commands, request and status codes, helpers.
// ----------------------------------------------------------------------------
package odq_pkg;

  localparam int CAPACITY = 16;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int KEY_W    = 16;
  localparam int VAL_W    = 16;
  localparam int POS_W    = 4;
  localparam int ENTRY_W  = KEY_W + VAL_W;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;
  } entry_t;

  typedef enum logic [2:0] {
    REQ_INS_FRONT = 3'd0,
    REQ_INS_BACK  = 3'd1,
    REQ_REMOVE    = 3'd2,
    REQ_READ_FWD  = 3'd3,
    REQ_READ_BWD  = 3'd4
  } req_type_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_FULL      = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    CMD_NONE       = 3'd0,
    CMD_PUSH_FRONT = 3'd1,
    CMD_PUSH_BACK  = 3'd2,
    CMD_REMOVE     = 3'd3,
    CMD_ROT_FWD    = 3'd4,
    CMD_ROT_BWD    = 3'd5
  } chain_cmd_t;

  typedef struct packed {
    chain_cmd_t cmd;
    entry_t     entry;
  } chain_req_t;

  typedef struct packed {
    logic [CAPACITY-1:0] valid_vec;
    logic [CAPACITY-1:0] hit_vec;
    logic                hit_any;
    logic [VAL_W-1:0]    hit_value;
    logic [CNT_W-1:0]    hit_idx;
    entry_t              head;
    entry_t              tail;
  } chain_stat_t;

  function automatic logic [POS_W-1:0] to_pos(input logic [CNT_W-1:0] v);
    logic [CNT_W+POS_W-1:0] t;
    t = {{POS_W{1'b0}}, v};
    return t[POS_W-1:0];
  endfunction

endpackage
`default_nettype wire

/* rtl/core/odq_cell.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// odq_cell: one list slot
// Holds one entry and its valid bit; shifts, loads or rotates on command.
// ----------------------------------------------------------------------------
module odq_cell (
  input  wire                       clk,
  input  wire                       rst_n,
  input  wire odq_pkg::chain_cmd_t  cmd,
  input  wire odq_pkg::entry_t      new_entry,
  input  wire odq_pkg::entry_t      prev_entry,
  input  wire                       prev_valid,
  input  wire odq_pkg::entry_t      next_entry,
  input  wire                       next_valid,
  input  wire odq_pkg::entry_t      head_entry,
  input  wire                       found_in,
  output odq_pkg::entry_t           entry,
  output logic                      valid,
  output logic                      found_out,
  output logic                      hit,
  output logic                      is_tail
);
  import odq_pkg::*;

  entry_t entry_r, entry_nxt;
  logic   valid_r, valid_nxt;
  logic   match;

  assign match     = valid_r && (entry_r.key == new_entry.key);
  assign found_out = found_in || match;
  assign hit       = (cmd == CMD_REMOVE) && match && !found_in;
  assign is_tail   = valid_r && !next_valid;
  assign entry     = entry_r;
  assign valid     = valid_r;

  always_comb begin
    entry_nxt = entry_r;
    valid_nxt = valid_r;
    unique case (cmd)
      CMD_PUSH_FRONT: begin
        entry_nxt = prev_entry;
        valid_nxt = prev_valid;
      end
      CMD_PUSH_BACK: begin
        if (!valid_r && prev_valid) begin
          entry_nxt = new_entry;
          valid_nxt = 1'b1;
        end
      end
      CMD_REMOVE: begin
        if (found_in || match) begin
          entry_nxt = next_entry;
          valid_nxt = next_valid;
        end
      end
      CMD_ROT_FWD: begin
        if (valid_r) entry_nxt = is_tail ? head_entry : next_entry;
      end
      CMD_ROT_BWD: begin
        if (valid_r) entry_nxt = prev_entry;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
    if (!rst_n) valid_r <= 1'b0;
    else        valid_r <= valid_nxt;
  end

endmodule
`default_nettype wire

/* rtl/core/odq_chain.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// odq_chain: row of list cells
// Links neighbors, ripples the first-match search and gathers head, tail
// and the matched entry.
// ----------------------------------------------------------------------------
module odq_chain (
  input  wire                        clk,
  input  wire                        rst_n,
  input  wire odq_pkg::chain_req_t   req,
  output odq_pkg::chain_stat_t       stat
);
  import odq_pkg::*;

  entry_t              ent    [CAPACITY];
  entry_t              prev_e [CAPACITY];
  entry_t              next_e [CAPACITY];
  logic [CAPACITY-1:0] vld;
  logic [CAPACITY-1:0] prev_v;
  logic [CAPACITY-1:0] next_v;
  logic [CAPACITY-1:0] hit;
  logic [CAPACITY-1:0] tail_m;
  logic [CAPACITY:0]   found;
  logic [ENTRY_W-1:0]  tail_acc;
  logic [VAL_W-1:0]    hit_val_acc;
  logic [CNT_W-1:0]    hit_idx_acc;
  entry_t              tail_entry;

  assign found[0] = 1'b0;

  genvar g;
  generate
    for (g = 0; g < CAPACITY; g++) begin : g_cell
      if (g == 0) begin : g_first
        assign prev_e[g] = (req.cmd == CMD_ROT_BWD) ? tail_entry : req.entry;
        assign prev_v[g] = 1'b1;
      end else begin : g_mid
        assign prev_e[g] = ent[g-1];
        assign prev_v[g] = vld[g-1];
      end
      if (g == CAPACITY - 1) begin : g_last
        assign next_e[g] = '0;
        assign next_v[g] = 1'b0;
      end else begin : g_inner
        assign next_e[g] = ent[g+1];
        assign next_v[g] = vld[g+1];
      end

      odq_cell u_cell (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (req.cmd),
        .new_entry  (req.entry),
        .prev_entry (prev_e[g]),
        .prev_valid (prev_v[g]),
        .next_entry (next_e[g]),
        .next_valid (next_v[g]),
        .head_entry (ent[0]),
        .found_in   (found[g]),
        .entry      (ent[g]),
        .valid      (vld[g]),
        .found_out  (found[g+1]),
        .hit        (hit[g]),
        .is_tail    (tail_m[g])
      );
    end
  endgenerate

  always_comb begin
    tail_acc    = '0;
    hit_val_acc = '0;
    hit_idx_acc = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (tail_m[i]) tail_acc = tail_acc | ent[i];
      if (hit[i]) begin
        hit_val_acc = hit_val_acc | ent[i].value;
        hit_idx_acc = hit_idx_acc | CNT_W'(i);
      end
    end
  end

  assign tail_entry     = tail_acc;
  assign stat.valid_vec = vld;
  assign stat.hit_vec   = hit;
  assign stat.hit_any   = found[CAPACITY] && (req.cmd == CMD_REMOVE);
  assign stat.hit_value = hit_val_acc;
  assign stat.hit_idx   = hit_idx_acc;
  assign stat.head      = ent[0];
  assign stat.tail      = tail_entry;

endmodule
`default_nettype wire

/* rtl/core/ordered_keyed_deque_top.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// ordered_keyed_deque_top: ordered key/value list with front/back access
// Keeps up to CAPACITY entries packed front to back in a row of cells.
// Input channel in_*: one request (type, key, value) per handshake.
// Output channel out_*: status, key, value, position and last marker.
// Insert front/back and remove by key each give one result, registered at
// the output in the cycle after the request is taken.
// A readout gives one result per entry, one per cycle while the receiver
// keeps taking them, by rotating the cell row one step per result; the row
// is back in place after the last. A readout request first moves the state
// to S_READ, which holds off new requests and registers each result; an
// empty list gives a single status result in the cycle after the request.
// Remove finds the first match in the same cycle through a ripple across
// all cells, then closes the gap by shifting the cells behind it.
// Reset empties the list at once; no clearing sweep is needed.
// A stalled receiver holds the output register; no new request is taken
// and no readout step advances until the held result is taken.
// Request types 5 to 7 are dropped without a result.
// ----------------------------------------------------------------------------
module ordered_keyed_deque_top (
  input  wire                       clk,
  input  wire                       rst_n,
  input  wire                       in_valid,
  output logic                      in_ready,
  input  wire  [2:0]                in_req_type,
  input  wire  [odq_pkg::KEY_W-1:0] in_entry_key,
  input  wire  [odq_pkg::VAL_W-1:0] in_entry_value,
  output logic                      out_valid,
  input  wire                       out_ready,
  output logic [1:0]                out_status,
  output logic [odq_pkg::KEY_W-1:0] out_key,
  output logic [odq_pkg::VAL_W-1:0] out_value,
  output logic [odq_pkg::POS_W-1:0] out_position,
  output logic                      out_last
);
  import odq_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_READ = 2'b10
  } state_t;

  state_t           state_r, state_nxt;
  logic             dir_bwd_r, dir_bwd_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [CNT_W-1:0] rd_idx_r, rd_idx_nxt;

  logic             out_valid_r, out_valid_nxt;
  status_t          out_status_r, out_status_nxt;
  logic [KEY_W-1:0] out_key_r, out_key_nxt;
  logic [VAL_W-1:0] out_value_r, out_value_nxt;
  logic [POS_W-1:0] out_pos_r, out_pos_nxt;
  logic             out_last_r, out_last_nxt;

  chain_req_t       creq;
  chain_stat_t      cstat;
  logic             out_free;
  logic             accept;
  logic             rd_last;
  logic [CNT_W-1:0] rd_pos;

  assign out_free = !out_valid_r || out_ready;
  assign in_ready = (state_r == S_IDLE) && out_free;
  assign accept   = in_valid && in_ready;
  assign rd_last  = (rd_idx_r == count_r - CNT_W'(1));
  assign rd_pos   = dir_bwd_r ? (count_r - CNT_W'(1) - rd_idx_r) : rd_idx_r;

  odq_chain u_chain (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (creq),
    .stat  (cstat)
  );

  always_comb begin
    creq.cmd         = CMD_NONE;
    creq.entry.key   = in_entry_key;
    creq.entry.value = in_entry_value;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          case (in_req_type) inside
            REQ_INS_FRONT: begin
              if (count_r != CNT_W'(CAPACITY)) creq.cmd = CMD_PUSH_FRONT;
            end
            REQ_INS_BACK: begin
              if (count_r != CNT_W'(CAPACITY)) creq.cmd = CMD_PUSH_BACK;
            end
            REQ_REMOVE: begin
              if (count_r != '0) creq.cmd = CMD_REMOVE;
            end
            default: ;
          endcase
        end
      end
      S_READ: begin
        if (out_free) creq.cmd = dir_bwd_r ? CMD_ROT_BWD : CMD_ROT_FWD;
      end
      default: ;
    endcase
  end

  always_comb begin
    state_nxt      = state_r;
    dir_bwd_nxt    = dir_bwd_r;
    count_nxt      = count_r;
    rd_idx_nxt     = rd_idx_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_status_nxt = out_status_r;
    out_key_nxt    = out_key_r;
    out_value_nxt  = out_value_r;
    out_pos_nxt    = out_pos_r;
    out_last_nxt   = out_last_r;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          case (in_req_type) inside
            REQ_INS_FRONT, REQ_INS_BACK: begin
              out_valid_nxt = 1'b1;
              out_key_nxt   = in_entry_key;
              out_value_nxt = in_entry_value;
              out_last_nxt  = 1'b1;
              out_pos_nxt   = '0;
              if (count_r == CNT_W'(CAPACITY)) begin
                out_status_nxt = ST_FULL;
              end else begin
                out_status_nxt = ST_OK;
                count_nxt      = count_r + CNT_W'(1);
                if (in_req_type == REQ_INS_BACK) out_pos_nxt = to_pos(count_r);
              end
            end
            REQ_REMOVE: begin
              out_valid_nxt = 1'b1;
              out_key_nxt   = in_entry_key;
              out_value_nxt = '0;
              out_pos_nxt   = '0;
              out_last_nxt  = 1'b1;
              if (count_r == '0) begin
                out_status_nxt = ST_EMPTY;
              end else begin
                if (cstat.hit_any) begin
                  out_status_nxt = ST_OK;
                  out_value_nxt  = cstat.hit_value;
                  out_pos_nxt    = to_pos(cstat.hit_idx);
                  count_nxt      = count_r - CNT_W'(1);
                end else begin
                  out_status_nxt = ST_NOT_FOUND;
                end
              end
            end
            REQ_READ_FWD, REQ_READ_BWD: begin
              if (count_r == '0) begin
                out_valid_nxt  = 1'b1;
                out_status_nxt = ST_EMPTY;
                out_key_nxt    = '0;
                out_value_nxt  = '0;
                out_pos_nxt    = '0;
                out_last_nxt   = 1'b1;
              end else begin
                state_nxt   = S_READ;
                dir_bwd_nxt = (in_req_type == REQ_READ_BWD);
                rd_idx_nxt  = '0;
              end
            end
            default: ;
          endcase
        end
      end
      S_READ: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = ST_OK;
          out_key_nxt    = dir_bwd_r ? cstat.tail.key : cstat.head.key;
          out_value_nxt  = dir_bwd_r ? cstat.tail.value : cstat.head.value;
          out_pos_nxt    = to_pos(rd_pos);
          out_last_nxt   = rd_last;
          rd_idx_nxt     = rd_idx_r + CNT_W'(1);
          if (rd_last) state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
    dir_bwd_r    <= dir_bwd_nxt;
    rd_idx_r     <= rd_idx_nxt;
    out_status_r <= out_status_nxt;
    out_key_r    <= out_key_nxt;
    out_value_r  <= out_value_nxt;
    out_pos_r    <= out_pos_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_valid    = out_valid_r;
  assign out_status   = out_status_r;
  assign out_key      = out_key_r;
  assign out_value    = out_value_r;
  assign out_position = out_pos_r;
  assign out_last     = out_last_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  a_valid_matches_count: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(cstat.valid_vec) == int'(count_r))
    else $error("cell valid bits disagree with entry count");

  a_single_hit: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(cstat.hit_vec))
    else $error("more than one cell claims the first match");

  a_read_holds_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_READ) |=> $stable(count_r))
    else $error("entry count changed during readout");

endmodule
`default_nettype wire
